// ===== src/humidity_temp_frame_decoder_core_defines.svh =====
// Assertion macros for the humidity/temperature frame decoder.
// Included by the top level; expects signals clk and rst in scope.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_CORE_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HTFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define HTFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/htfd_pkg.sv =====
// Shared types and constants for the humidity/temperature frame decoder.
// No dependencies; imported by every module of the block.
package htfd_pkg;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_CRC  = 2'd1,
    ERR_ZERO = 2'd2,
    ERR_BUS  = 2'd3
  } err_code_t;

  typedef enum logic {
    STAGE_TEMP = 1'b0,
    STAGE_HUM  = 1'b1
  } stage_t;

  typedef enum logic [1:0] {
    POS_MSB   = 2'd0,
    POS_LSB   = 2'd1,
    POS_CRC   = 2'd2,
    POS_SPARE = 2'd3
  } pos_t;

  // One queued job: an error report or a finished reading.
  typedef struct packed {
    err_code_t   err;
    stage_t      stage;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } job_t;

  localparam int          HTFD_QUEUE_DEPTH = 4;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [15:0] RAW_MASK    = 16'hFFFC;
  localparam logic [14:0] TEMP_SCALE  = 15'd17572;
  localparam logic [15:0] TEMP_OFFSET = 16'd4685;
  localparam logic [13:0] HUM_SCALE   = 14'd12500;
  localparam logic [13:0] HUM_OFFSET  = 14'd600;
  localparam logic [13:0] HUM_MAX     = 14'd10000;

endpackage

// ===== src/htfd_front.sv =====
// Front end: takes sensor bytes, tracks frame position, checks CRC and zero
// readings, and pushes one job per result. Depends on htfd_pkg.
module htfd_front
  import htfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       seq_start,
  input  logic       bus_fault,
  output logic       push_valid,
  output job_t       push_job
);

  pos_t        pos, pos_next;
  stage_t      stage, stage_next;
  logic [7:0]  high_byte, high_byte_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [7:0]  crc_acc, crc_acc_next;
  logic [15:0] temp_raw, temp_raw_next;

  pos_t        pos_eff;
  stage_t      stage_eff;
  logic [15:0] raw;
  logic        crc_ok;
  logic        raw_zero;

  // CRC-8 over one byte, MSB first, poly 0x31
  function automatic logic [7:0] crc8_byte(input logic [7:0] din);
    logic [7:0] c;
    c = din;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  assign pos_eff   = seq_start ? POS_MSB : pos;
  assign stage_eff = seq_start ? STAGE_TEMP : stage;
  assign raw       = {high_byte, low_byte} & RAW_MASK;
  assign crc_ok    = (crc_acc == data_byte);
  assign raw_zero  = (raw == 16'd0);

  // next state
  always_comb begin
    pos_next       = pos;
    stage_next     = stage;
    high_byte_next = high_byte;
    low_byte_next  = low_byte;
    crc_acc_next   = crc_acc;
    temp_raw_next  = temp_raw;
    if (take) begin
      if (bus_fault) begin
        pos_next   = POS_MSB;
        stage_next = STAGE_TEMP;
      end else begin
        unique case (pos_eff)
          POS_LSB: begin
            low_byte_next = data_byte;
            crc_acc_next  = crc8_byte(crc_acc ^ data_byte);
            pos_next      = POS_CRC;
            stage_next    = stage_eff;
          end
          POS_CRC: begin
            pos_next = POS_MSB;
            if (!crc_ok || raw_zero || (stage_eff == STAGE_HUM)) begin
              stage_next = STAGE_TEMP;
            end else begin
              temp_raw_next = raw;
              stage_next    = STAGE_HUM;
            end
          end
          POS_MSB, POS_SPARE: begin
            high_byte_next = data_byte;
            crc_acc_next   = crc8_byte(data_byte);
            pos_next       = POS_LSB;
            stage_next     = stage_eff;
          end
        endcase
      end
    end
  end

  // job output
  always_comb begin
    push_job.stage = stage_eff;
    push_job.raw_t = temp_raw;
    push_job.raw_h = raw;
    priority if (bus_fault) begin
      push_job.err = ERR_BUS;
    end else if (!crc_ok) begin
      push_job.err = ERR_CRC;
    end else if (raw_zero) begin
      push_job.err = ERR_ZERO;
    end else begin
      push_job.err = ERR_NONE;
    end
    push_valid = take && (bus_fault ||
                 ((pos_eff == POS_CRC) &&
                  (!crc_ok || raw_zero || (stage_eff == STAGE_HUM))));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_MSB;
      stage <= STAGE_TEMP;
    end else begin
      pos   <= pos_next;
      stage <= stage_next;
    end
    high_byte <= high_byte_next;
    low_byte  <= low_byte_next;
    crc_acc   <= crc_acc_next;
    temp_raw  <= temp_raw_next;
  end

endmodule

// ===== src/htfd_queue.sv =====
// Small job queue between front and back end, register based.
// Depends on htfd_pkg for the job type.
module htfd_queue
  import htfd_pkg::*;
#(
  parameter int DEPTH = HTFD_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/htfd_back.sv =====
// Back end: scales raw readings (multiply stage, then offset/clamp stage)
// and holds the result in the output register. Depends on htfd_pkg.
module htfd_back
  import htfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  job_t               pop_job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] temperature_centi,
  output logic        [13:0] humidity_centi,
  output logic               reading_valid,
  output logic        [1:0]  error_code,
  output logic               failed_stage
);

  logic        a_valid;
  err_code_t   a_err;
  stage_t      a_stage;
  logic [30:0] a_tprod;
  logic [29:0] a_hprod;

  logic        a_take, b_load;
  logic [15:0] t_wide;
  logic [13:0] h_scaled, h_off;

  assign b_load    = a_valid && (!out_valid || out_ready);
  assign pop_ready = !a_valid || b_load;
  assign a_take    = pop_valid && pop_ready;

  assign t_wide   = {1'b0, a_tprod[30:16]} - TEMP_OFFSET;
  assign h_scaled = a_hprod[29:16];

  always_comb begin
    if (h_scaled < HUM_OFFSET) begin
      h_off = '0;
    end else begin
      h_off = h_scaled - HUM_OFFSET;
    end
    if (h_off > HUM_MAX) begin
      h_off = HUM_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_take) begin
        a_valid <= 1'b1;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
      if (b_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (a_take) begin
      a_err   <= pop_job.err;
      a_stage <= pop_job.stage;
      a_tprod <= TEMP_SCALE * pop_job.raw_t;
      a_hprod <= HUM_SCALE * pop_job.raw_h;
    end
    if (b_load) begin
      error_code <= a_err;
      if (a_err == ERR_NONE) begin
        temperature_centi <= signed'(t_wide[14:0]);
        humidity_centi    <= h_off;
        reading_valid     <= 1'b1;
        failed_stage      <= STAGE_TEMP;
      end else begin
        temperature_centi <= '0;
        humidity_centi    <= '0;
        reading_valid     <= 1'b0;
        failed_stage      <= a_stage;
      end
    end
  end

endmodule

// ===== src/humidity_temp_frame_decoder_core.sv =====
// Humidity/temperature frame decoder, top level. Takes the six bytes a
// sensor returns (temperature frame then humidity frame: MSB, LSB, CRC-8 with
// poly 0x31 and init 0), checks each frame and reports one result per full
// read or per failure. A valid result carries temperature in 0.01 degC,
// floor(17572*raw/65536)-4685, and humidity in 0.01 %RH,
// floor(12500*raw/65536)-600 clamped to 0..10000. CRC mismatch, a zero
// reading or bus_fault gives an invalid result (error_code 1/2/3, failed_stage
// the frame in progress) and restarts at the temperature frame; seq_start
// forces the byte to be a temperature MSB. One byte is accepted per cycle
// while in_ready is high. The front end classifies each byte and pushes a job
// in the same cycle into a 4-entry queue (QUEUE_DEPTH); the back end takes it
// through a multiply stage, then offset/clamp into the output register, so a
// result crosses the queue and both back-end registers after its last byte,
// later only while out_ready holds results back. in_ready drops only when the
// queue is full, i.e. while out_ready has been low long enough to back it up.
// Depends on htfd_pkg, htfd_front, htfd_queue, htfd_back and the defines header.
`include "humidity_temp_frame_decoder_core_defines.svh"

module humidity_temp_frame_decoder_core
  import htfd_pkg::*;
#(
  parameter int QUEUE_DEPTH = HTFD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // byte input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [7:0]  data_byte,
  input  logic               seq_start,
  input  logic               bus_fault,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] temperature_centi,
  output logic        [13:0] humidity_centi,
  output logic               reading_valid,
  output logic        [1:0]  error_code,
  output logic               failed_stage
);

  logic take;
  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // bytes are taken whenever the queue has room for a possible job
  assign in_ready = push_ready;
  assign take     = in_valid && in_ready;

  htfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (data_byte),
    .seq_start  (seq_start),
    .bus_fault  (bus_fault),
    .push_valid (push_valid),
    .push_job   (push_job)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  htfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .pop_valid         (pop_valid),
    .pop_ready         (pop_ready),
    .pop_job           (pop_job),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .reading_valid     (reading_valid),
    .error_code        (error_code),
    .failed_stage      (failed_stage)
  );

  // valid readings carry no error and report the temperature stage
  `HTFD_ASSERT_IMPL(a_valid_clean, out_valid && reading_valid,
                    (error_code == ERR_NONE) && !failed_stage,
                    "valid reading with error fields set")

  // invalid results have zeroed values and a real error code
  `HTFD_ASSERT_IMPL(a_invalid_zero, out_valid && !reading_valid,
                    (temperature_centi == 15'sd0) && (humidity_centi == 14'd0) &&
                    (error_code != ERR_NONE),
                    "invalid result fields not cleared")

  // humidity clamp
  `HTFD_ASSERT_IMPL(a_hum_range, out_valid, humidity_centi <= HUM_MAX, "humidity above clamp")

  // a bus fault always queues a job
  `HTFD_ASSERT_NEXT(a_fault_queued, take && bus_fault, pop_valid, "bus fault produced no job")

endmodule
